FILE: sv/hpid_pkg.sv
`default_nettype none

package hpid_pkg;

    // Sizing
    localparam int HEATERS       = 4;
    localparam int HIST_DEPTH    = 4;
    localparam int PTR_W         = $clog2(HIST_DEPTH);
    localparam int SCALE_LOG2    = 10;                 // loop scale 1024
    localparam int HYSTERESIS    = 2;
    localparam int MARGIN        = HYSTERESIS * 4;     // quarter degrees

    // Field widths
    localparam int HEATER_W      = 2;
    localparam int TEMP_W        = 12;
    localparam int LEVEL_W       = 8;
    localparam int GAIN_W        = 20;
    localparam int LIM_W         = 15;
    localparam int INT_W         = 16;
    localparam int ERR_W         = TEMP_W + 1;
    localparam int CNT_W         = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 20;

    // Sanity tracker and output level constants
    localparam int HEAT_STALL_MAX   = 40;
    localparam int COOL_STALL_MAX   = 125;
    localparam int COOL_FOLLOW_TEMP = 240;
    localparam int PIN_ON_MIN       = 8;
    localparam int LEVEL_MAX        = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_GAIN     = 3'd0,
        REG_I_GAIN     = 3'd1,
        REG_D_GAIN     = 3'd2,
        REG_INT_LIMIT  = 3'd3,
        REG_BANG_MODE  = 3'd4,
        REG_ON_LEVEL   = 3'd5,
        REG_OFF_LEVEL  = 3'd6,
        REG_SANITY_EN  = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_MANUAL = 1'b1
    } op_t;

    typedef struct packed {
        logic [TEMP_W-1:0] sane;
        logic [CNT_W-1:0]  count;
    } sanity_state_t;

endpackage

`default_nettype wire

FILE: sv/hpid_sanity.sv
`default_nettype none

// Heater sanity tracker: next tracker state and fault verdict for one tick.
module hpid_sanity (
    input  wire logic [hpid_pkg::TEMP_W-1:0] cur,
    input  wire logic [hpid_pkg::TEMP_W-1:0] tgt,
    input  wire hpid_pkg::sanity_state_t     state_in,
    output hpid_pkg::sanity_state_t          state_out,
    output logic                             fault
);

    localparam int SW = hpid_pkg::TEMP_W + 2;

    logic signed [SW-1:0]          cur_s, tgt_s, s, diff, adiff;
    logic [hpid_pkg::CNT_W-1:0]    cnt;

    assign cur_s = $signed({2'b00, cur});
    assign tgt_s = $signed({2'b00, tgt});

    always_comb begin
        s   = $signed({2'b00, state_in.sane});
        cnt = state_in.count;
        if (tgt_s > cur_s + SW'(hpid_pkg::MARGIN)) begin
            // heating: temperature must keep rising
            if (cur_s > s) begin
                s = cur_s;
            end else if (cnt < hpid_pkg::CNT_W'(hpid_pkg::HEAT_STALL_MAX)) begin
                cnt = cnt + 1'b1;
            end else begin
                cnt = '0;
                s   = s + SW'(1);
            end
            if (s > tgt_s) s = tgt_s;
        end else if (tgt_s < cur_s - SW'(hpid_pkg::MARGIN)) begin
            // cooling: temperature must keep falling
            if (cur_s < s) begin
                s = cur_s;
            end else if (cnt < hpid_pkg::CNT_W'(hpid_pkg::COOL_STALL_MAX)) begin
                cnt = cnt + 1'b1;
            end else begin
                cnt = '0;
                s   = s - SW'(1);
            end
            if (cur_s <= SW'(hpid_pkg::COOL_FOLLOW_TEMP)) s = cur_s;
            else if (s < tgt_s) s = tgt_s;
        end else begin
            s   = cur_s;
            cnt = '0;
        end
        diff  = cur_s - s;
        adiff = diff[SW-1] ? -diff : diff;
    end

    assign state_out.sane  = s[hpid_pkg::TEMP_W-1:0];
    assign state_out.count = cnt;
    assign fault           = adiff > SW'(hpid_pkg::MARGIN);

endmodule

`default_nettype wire

FILE: sv/heater_pid_with_sanity_check_top.sv
// Per-heater PID temperature loop with heater sanity tracker.
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser selects a
// control tick (0) or a manual drive level set (1). Every item for a heater
// in range returns exactly one result item on m_tvalid/m_tready/m_tdata.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata). The
// user must write it only while no item is in flight; the block does not
// enforce this. Gains are shared by all heaters. Pipeline: input register,
// state update stage (integrator, history ring, sanity tracker), multiply
// stage (three products), sum/scale/clamp stage that feeds the result
// register. One item per cycle is sustained while the receiver does not
// stall: per-heater state is read and written within the state update stage,
// so back-to-back items for the same heater see each other's updates.
// When the receiver stalls the result register holds; earlier stages keep
// filling until every stage holds an item, then s_tready drops.
// Reset (aresetn low, synchronous) restores default gains and clears all
// per-heater state and the pipeline valid flags.
`default_nettype none

module heater_pid_with_sanity_check_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [hpid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hpid_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [1:0] heater_index, [13:2] measured_temp, [25:14] setpoint,
    // [33:26] manual_level, [39:34] zero
    input  wire logic [39:0]                       s_tdata,
    // [0] operation
    input  wire logic [0:0]                        s_tuser,
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] heater_out_index, [9:2] drive_level, [10] pin_on, [11] fault,
    // [12] all_heaters_off, [15:13] zero
    output logic [15:0]                            m_tdata
);

    localparam int HW   = hpid_pkg::HEATER_W;
    localparam int TW   = hpid_pkg::TEMP_W;
    localparam int LW   = hpid_pkg::LEVEL_W;
    localparam int GW   = hpid_pkg::GAIN_W;
    localparam int IW   = hpid_pkg::INT_W;
    localparam int EW   = hpid_pkg::ERR_W;
    localparam int PW   = hpid_pkg::PTR_W;
    localparam int NH   = hpid_pkg::HEATERS;
    localparam int ND   = hpid_pkg::HIST_DEPTH;
    localparam int PEW  = EW + GW + 1;          // err and d products
    localparam int PIW  = IW + GW + 1;          // integrator product
    localparam int SUMW = PIW + 2;

    typedef enum logic [1:0] {
        KIND_MANUAL,
        KIND_OFF,
        KIND_BANG,
        KIND_PID
    } kind_t;

    // ---------------- configuration ----------------
    logic [GW-1:0]                p_gain_reg, i_gain_reg, d_gain_reg;
    logic [hpid_pkg::LIM_W-1:0]   int_limit_reg;
    logic                         bang_mode_reg, sanity_en_reg;
    logic [LW-1:0]                on_level_reg, off_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg    <= GW'(8192);
            i_gain_reg    <= GW'(512);
            d_gain_reg    <= GW'(24576);
            int_limit_reg <= hpid_pkg::LIM_W'(384);
            bang_mode_reg <= 1'b0;
            on_level_reg  <= LW'(hpid_pkg::LEVEL_MAX);
            off_level_reg <= '0;
            sanity_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (hpid_pkg::cfg_reg_t'(cfg_index))
                hpid_pkg::REG_P_GAIN:    p_gain_reg    <= cfg_wdata[GW-1:0];
                hpid_pkg::REG_I_GAIN:    i_gain_reg    <= cfg_wdata[GW-1:0];
                hpid_pkg::REG_D_GAIN:    d_gain_reg    <= cfg_wdata[GW-1:0];
                hpid_pkg::REG_INT_LIMIT: int_limit_reg <= cfg_wdata[hpid_pkg::LIM_W-1:0];
                hpid_pkg::REG_BANG_MODE: bang_mode_reg <= cfg_wdata[0];
                hpid_pkg::REG_ON_LEVEL:  on_level_reg  <= cfg_wdata[LW-1:0];
                hpid_pkg::REG_OFF_LEVEL: off_level_reg <= cfg_wdata[LW-1:0];
                hpid_pkg::REG_SANITY_EN: sanity_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, m_valid_reg;
    logic en_a, en_b, en_c, en_m;

    assign en_m     = !m_valid_reg || m_tready;
    assign en_c     = !c_valid_reg || en_m;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;

    // ---------------- stage A: input register ----------------
    logic          a_op_reg;
    logic [HW-1:0] a_h_reg;
    logic [TW-1:0] a_cur_reg, a_tgt_reg;
    logic [LW-1:0] a_man_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= s_tvalid;
        end
        if (en_a && s_tvalid) begin
            a_op_reg  <= s_tuser[0];
            a_h_reg   <= s_tdata[1:0];
            a_cur_reg <= s_tdata[13:2];
            a_tgt_reg <= s_tdata[25:14];
            a_man_reg <= s_tdata[33:26];
        end
    end

    // ---------------- stage B: per-heater state update ----------------
    logic signed [IW-1:0]  integ_reg [NH];
    logic [TW-1:0]         hist_reg  [NH][ND];
    logic [PW-1:0]         ptr_reg   [NH];
    hpid_pkg::sanity_state_t san_reg [NH];

    logic                    a_in_range, a_go, a_tick, a_pid;
    logic signed [EW-1:0]    err, dval;
    logic signed [IW:0]      int_sum, lim_s;
    logic signed [IW-1:0]    acc;
    logic [PW-1:0]           ptr_cur, ptr_nx;
    hpid_pkg::sanity_state_t san_nx;
    logic                    san_fault;
    kind_t                   a_kind;
    logic [LW-1:0]           a_level;

    assign a_in_range = int'(a_h_reg) < NH;
    assign a_go       = a_valid_reg && en_b && a_in_range;
    assign a_tick     = (hpid_pkg::op_t'(a_op_reg) == hpid_pkg::OP_TICK) && (a_tgt_reg != '0);
    assign a_pid      = a_tick && !bang_mode_reg;

    assign err     = $signed({1'b0, a_tgt_reg}) - $signed({1'b0, a_cur_reg});
    assign int_sum = (IW+1)'(integ_reg[a_h_reg]) + (IW+1)'(err);
    assign lim_s   = $signed({2'b00, int_limit_reg});

    always_comb begin
        if (int_sum > lim_s)       acc = lim_s[IW-1:0];
        else if (int_sum < -lim_s) acc = IW'(-lim_s);
        else                       acc = int_sum[IW-1:0];
    end

    // the derivative reads the ring slot after the one just written
    assign ptr_cur = ptr_reg[a_h_reg];
    assign ptr_nx  = (ptr_cur == PW'(ND - 1)) ? '0 : ptr_cur + 1'b1;
    assign dval    = $signed({1'b0, hist_reg[a_h_reg][ptr_nx]}) - $signed({1'b0, a_cur_reg});

    hpid_sanity u_sanity (
        .cur       (a_cur_reg),
        .tgt       (a_tgt_reg),
        .state_in  (san_reg[a_h_reg]),
        .state_out (san_nx),
        .fault     (san_fault)
    );

    always_comb begin
        if (hpid_pkg::op_t'(a_op_reg) == hpid_pkg::OP_MANUAL) begin
            a_kind  = KIND_MANUAL;
            a_level = a_man_reg;
        end else if (a_tgt_reg == '0) begin
            a_kind  = KIND_OFF;
            a_level = '0;
        end else if (bang_mode_reg) begin
            a_kind  = KIND_BANG;
            a_level = (a_cur_reg >= a_tgt_reg) ? off_level_reg : on_level_reg;
        end else begin
            a_kind  = KIND_PID;
            a_level = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int h = 0; h < NH; h++) begin
                integ_reg[h] <= '0;
                ptr_reg[h]   <= '0;
                san_reg[h]   <= '0;
                for (int k = 0; k < ND; k++) hist_reg[h][k] <= '0;
            end
        end else if (a_go) begin
            if (a_pid) begin
                integ_reg[a_h_reg]          <= acc;
                hist_reg[a_h_reg][ptr_cur]  <= a_cur_reg;
                ptr_reg[a_h_reg]            <= ptr_nx;
            end
            if (a_tick && sanity_en_reg) san_reg[a_h_reg] <= san_nx;
        end
    end

    kind_t                b_kind_reg;
    logic [HW-1:0]        b_h_reg;
    logic [LW-1:0]        b_level_reg;
    logic                 b_fault_reg;
    logic signed [EW-1:0] b_err_reg, b_d_reg;
    logic signed [IW-1:0] b_acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg && a_in_range;
        end
        if (a_go) begin
            b_kind_reg  <= a_kind;
            b_h_reg     <= a_h_reg;
            b_level_reg <= a_level;
            b_fault_reg <= a_tick && sanity_en_reg && san_fault;
            b_err_reg   <= err;
            b_d_reg     <= dval;
            b_acc_reg   <= acc;
        end
    end

    // ---------------- stage C: products ----------------
    kind_t                 c_kind_reg;
    logic [HW-1:0]         c_h_reg;
    logic [LW-1:0]         c_level_reg;
    logic                  c_fault_reg;
    logic signed [PEW-1:0] c_pp_reg, c_dp_reg;
    logic signed [PIW-1:0] c_ip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= b_valid_reg;
        end
        if (en_c && b_valid_reg) begin
            c_kind_reg  <= b_kind_reg;
            c_h_reg     <= b_h_reg;
            c_level_reg <= b_level_reg;
            c_fault_reg <= b_fault_reg;
            c_pp_reg    <= b_err_reg * $signed({1'b0, p_gain_reg});
            c_ip_reg    <= b_acc_reg * $signed({1'b0, i_gain_reg});
            c_dp_reg    <= b_d_reg   * $signed({1'b0, d_gain_reg});
        end
    end

    // ---------------- stage D: sum, scale, clamp, result register ----------------
    logic signed [SUMW-1:0] sum, biased, q;
    logic [LW-1:0]          pid_level, lvl;
    logic [LW-1:0]          last_reg  [NH];
    logic [LW-1:0]          last_next [NH];
    logic                   all_off;
    logic                   c_go;

    assign c_go = c_valid_reg && en_m;

    // divide by the loop scale, truncating toward zero
    assign sum    = SUMW'(c_pp_reg) + SUMW'(c_ip_reg) + SUMW'(c_dp_reg);
    assign biased = sum[SUMW-1] ? sum + SUMW'((1 << hpid_pkg::SCALE_LOG2) - 1) : sum;
    assign q      = biased >>> hpid_pkg::SCALE_LOG2;

    always_comb begin
        if (q > SUMW'(hpid_pkg::LEVEL_MAX)) pid_level = LW'(hpid_pkg::LEVEL_MAX);
        else if (q < 0)                     pid_level = '0;
        else                                pid_level = q[LW-1:0];
    end

    always_comb begin
        if (c_fault_reg)                lvl = '0;  // tracker forces shutdown
        else if (c_kind_reg == KIND_PID) lvl = pid_level;
        else                            lvl = c_level_reg;
    end

    always_comb begin
        for (int h = 0; h < NH; h++) last_next[h] = last_reg[h];
        last_next[c_h_reg] = lvl;
        all_off = 1'b1;
        for (int h = 0; h < NH; h++) if (last_next[h] != '0) all_off = 1'b0;
    end

    logic [HW-1:0] m_h_reg;
    logic [LW-1:0] m_level_reg;
    logic          m_pin_reg, m_fault_reg, m_alloff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int h = 0; h < NH; h++) last_reg[h] <= '0;
        end else begin
            if (en_m) m_valid_reg <= c_valid_reg;
            if (c_go) begin
                for (int h = 0; h < NH; h++) last_reg[h] <= last_next[h];
            end
        end
        if (c_go) begin
            m_h_reg      <= c_h_reg;
            m_level_reg  <= lvl;
            m_pin_reg    <= lvl >= LW'(hpid_pkg::PIN_ON_MIN);
            m_fault_reg  <= c_fault_reg;
            m_alloff_reg <= all_off;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_alloff_reg, m_fault_reg, m_pin_reg, m_level_reg, m_h_reg};

    // ---------------- assertions ----------------
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_fault_reg |-> m_level_reg == '0)
        else $error("fault result with nonzero level");

    a_pin_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_pin_reg == (m_level_reg >= LW'(hpid_pkg::PIN_ON_MIN)))
        else $error("pin_on disagrees with level");

    a_all_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_level_reg != '0 |-> !m_alloff_reg)
        else $error("all_heaters_off with a heater driven");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |=> $stable(integ_reg[0]) && $stable(ptr_reg[0]))
        else $error("heater state changed without an item");

endmodule

`default_nettype wire
